>>> hdl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, types and polynomial constants of the tanh soft clipper.
// ----------------------------------------------------------------------------
package pts_pkg;

    // input sample format
    localparam int IN_W         = 32;
    localparam int IN_FRAC_BITS = 27;
    localparam int F2           = 2 * IN_FRAC_BITS;
    localparam int SCALE_W      = 31;

    // multiplier geometry: A digits x B digits of 32 bits each
    localparam int DIG_W   = 32;
    localparam int MA_DIG  = 7;
    localparam int MB_DIG  = 2;
    localparam int MA_W    = MA_DIG * DIG_W;
    localparam int MB_W    = MB_DIG * DIG_W;
    localparam int ROW_W   = MA_W + DIG_W;
    localparam int MP_W    = 288;
    localparam int MUL_LAT = 3;

    // divider: quotient bits below the saturation point
    localparam int QUO_W = 31;

    typedef logic [MA_W-1:0]    mula_t;
    typedef logic [MB_W-1:0]    mulb_t;
    typedef logic [MP_W-1:0]    prod_t;
    typedef logic [QUO_W-1:0]   quo_t;

    // Horner constants, already scaled to the fixed-point grid
    localparam mula_t P1_K = MA_W'(378)  << F2;
    localparam mula_t Q1_K = MA_W'(3150) << F2;
    localparam prod_t P2_K = MP_W'(17325)  << (2 * F2);
    localparam prod_t Q2_K = MP_W'(62370)  << (2 * F2);
    localparam prod_t P3_K = MP_W'(135135) << (3 * F2);
    localparam prod_t Q3_K = MP_W'(135135) << (3 * F2);

    localparam logic [IN_W-1:0] SAT_MAG = {1'b0, {(IN_W-1){1'b1}}};

endpackage

>>> hdl/pade_tanh_soft_clip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pade_tanh_soft_clip_core
// Soft clipper: scale * x*P(x^2)/Q(x^2) (7/6 Pade tanh), truncated, saturated.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_sample_in             | in
//  result  | m_valid m_ready m_sample_out m_saturated| out
//  config  | cfg_wr_en cfg_wr_data (output_scale)    | in
//
// One item per clock sustained while the output is not stalled; the pipeline
// depth is set by the four chained multiply-add units and the one stage
// per quotient bit of the restoring divider.
// Reset clears all valid bits and loads output_scale with full scale.
// A stall at the output freezes every stage together; nothing is lost.
// ----------------------------------------------------------------------------
module pade_tanh_soft_clip_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pts_pkg::SCALE_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [pts_pkg::IN_W-1:0] s_sample_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [pts_pkg::IN_W-1:0] m_sample_out,
    output logic                        m_saturated
);
    import pts_pkg::*;

    logic en;
    logic [SCALE_W-1:0] scale_reg;

    // input stage
    logic            v0_reg, neg0_reg;
    logic [IN_W-1:0] mag0_reg, raw, mag_in;

    // after first multiply (u = mag^2, ms = mag*scale)
    logic  v1_reg [MUL_LAT];
    logic  n1_reg [MUL_LAT];
    prod_t u_prod, ms_prod;

    // first Horner step
    logic  vp_reg, np_reg;
    mula_t p1_reg, q1_reg;
    mulb_t up_reg, msp_reg;

    // second and third Horner steps, final numerator product
    logic  v2_reg [MUL_LAT];
    logic  n2_reg [MUL_LAT];
    mulb_t u2_reg [MUL_LAT];
    mulb_t ms2_reg [MUL_LAT];
    prod_t p2_prod, q2_prod;
    logic  v3_reg [MUL_LAT];
    logic  n3_reg [MUL_LAT];
    mulb_t ms3_reg [MUL_LAT];
    prod_t p3_prod, q3_prod;
    logic  v4_reg [MUL_LAT];
    logic  n4_reg [MUL_LAT];
    prod_t den4_reg [MUL_LAT];
    prod_t num_prod;

    // divider stages: index 0 is the saturation check
    logic  dv_reg   [QUO_W+1];
    logic  dneg_reg [QUO_W+1];
    logic  dsat_reg [QUO_W+1];
    prod_t drem_reg [QUO_W+1];
    prod_t dden_reg [QUO_W+1];
    quo_t  dquo_reg [QUO_W+1];
    logic [MP_W:0] trial [QUO_W];

    // output register
    logic            m_valid_reg, m_sat_reg;
    logic [IN_W-1:0] out_reg, omag;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // full-scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SAT_MAG[SCALE_W-1:0];
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    // magnitude and sign; the most negative code keeps its full magnitude
    assign raw    = s_sample_in;
    assign mag_in = raw[IN_W-1] ? (~raw + IN_W'(1)) : raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg <= mag_in;
            neg0_reg <= raw[IN_W-1];
        end
    end

    // u = mag^2 and ms = mag * scale
    pts_mul u_mul (
        .aclk (aclk), .en (en),
        .a (MA_W'(mag0_reg)), .b (MB_W'(mag0_reg)), .c ('0), .p (u_prod)
    );
    pts_mul ms_mul (
        .aclk (aclk), .en (en),
        .a (MA_W'(mag0_reg)), .b (MB_W'(scale_reg)), .c ('0), .p (ms_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) v1_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg[0] <= v0_reg;
            for (int i = 1; i < MUL_LAT; i++) v1_reg[i] <= v1_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg[0] <= neg0_reg;
            for (int i = 1; i < MUL_LAT; i++) n1_reg[i] <= n1_reg[i-1];
        end
    end

    // first Horner step: p1 = u + 378D, q1 = 28u + 3150D
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= v1_reg[MUL_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            np_reg  <= n1_reg[MUL_LAT-1];
            up_reg  <= u_prod[MB_W-1:0];
            msp_reg <= ms_prod[MB_W-1:0];
            p1_reg  <= MA_W'(u_prod[MB_W-1:0]) + P1_K;
            q1_reg  <= (MA_W'(u_prod[MB_W-1:0]) << 5) - (MA_W'(u_prod[MB_W-1:0]) << 2)
                       + Q1_K;
        end
    end

    // second Horner step
    pts_mul p2_mul (
        .aclk (aclk), .en (en), .a (p1_reg), .b (up_reg), .c (P2_K), .p (p2_prod)
    );
    pts_mul q2_mul (
        .aclk (aclk), .en (en), .a (q1_reg), .b (up_reg), .c (Q2_K), .p (q2_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) v2_reg[i] <= 1'b0;
        end else if (en) begin
            v2_reg[0] <= vp_reg;
            for (int i = 1; i < MUL_LAT; i++) v2_reg[i] <= v2_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_reg[0]  <= np_reg;
            u2_reg[0]  <= up_reg;
            ms2_reg[0] <= msp_reg;
            for (int i = 1; i < MUL_LAT; i++) begin
                n2_reg[i]  <= n2_reg[i-1];
                u2_reg[i]  <= u2_reg[i-1];
                ms2_reg[i] <= ms2_reg[i-1];
            end
        end
    end

    // third Horner step
    pts_mul p3_mul (
        .aclk (aclk), .en (en), .a (p2_prod[MA_W-1:0]), .b (u2_reg[MUL_LAT-1]),
        .c (P3_K), .p (p3_prod)
    );
    pts_mul q3_mul (
        .aclk (aclk), .en (en), .a (q2_prod[MA_W-1:0]), .b (u2_reg[MUL_LAT-1]),
        .c (Q3_K), .p (q3_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) v3_reg[i] <= 1'b0;
        end else if (en) begin
            v3_reg[0] <= v2_reg[MUL_LAT-1];
            for (int i = 1; i < MUL_LAT; i++) v3_reg[i] <= v3_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg[0]  <= n2_reg[MUL_LAT-1];
            ms3_reg[0] <= ms2_reg[MUL_LAT-1];
            for (int i = 1; i < MUL_LAT; i++) begin
                n3_reg[i]  <= n3_reg[i-1];
                ms3_reg[i] <= ms3_reg[i-1];
            end
        end
    end

    // numerator = P * mag * scale; divisor = Q * 2^IN_FRAC_BITS
    pts_mul num_mul (
        .aclk (aclk), .en (en), .a (p3_prod[MA_W-1:0]), .b (ms3_reg[MUL_LAT-1]),
        .c ('0), .p (num_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUL_LAT; i++) v4_reg[i] <= 1'b0;
        end else if (en) begin
            v4_reg[0] <= v3_reg[MUL_LAT-1];
            for (int i = 1; i < MUL_LAT; i++) v4_reg[i] <= v4_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n4_reg[0]   <= n3_reg[MUL_LAT-1];
            den4_reg[0] <= q3_prod << IN_FRAC_BITS;
            for (int i = 1; i < MUL_LAT; i++) begin
                n4_reg[i]   <= n4_reg[i-1];
                den4_reg[i] <= den4_reg[i-1];
            end
        end
    end

    // trial subtractions, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            trial[k] = {1'b0, drem_reg[k]} - {1'b0, dden_reg[k] << (QUO_W-1-k)};
        end
    end

    // divider valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QUO_W; k++) dv_reg[k] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v4_reg[MUL_LAT-1];
            for (int k = 0; k < QUO_W; k++) dv_reg[k+1] <= dv_reg[k];
        end
    end

    // saturation check, then restoring division
    always_ff @(posedge aclk) begin
        if (en) begin
            dneg_reg[0] <= n4_reg[MUL_LAT-1];
            dden_reg[0] <= den4_reg[MUL_LAT-1];
            drem_reg[0] <= num_prod;
            dquo_reg[0] <= '0;
            dsat_reg[0] <= num_prod >= (den4_reg[MUL_LAT-1] << QUO_W);
            for (int k = 0; k < QUO_W; k++) begin
                dneg_reg[k+1] <= dneg_reg[k];
                dden_reg[k+1] <= dden_reg[k];
                dsat_reg[k+1] <= dsat_reg[k];
                if (!trial[k][MP_W]) begin
                    drem_reg[k+1] <= trial[k][MP_W-1:0];
                    dquo_reg[k+1] <= dquo_reg[k] | (QUO_W'(1) << (QUO_W-1-k));
                end else begin
                    drem_reg[k+1] <= drem_reg[k];
                    dquo_reg[k+1] <= dquo_reg[k];
                end
            end
        end
    end

    // sign, saturation and output register
    assign omag = dsat_reg[QUO_W] ? SAT_MAG : {1'b0, dquo_reg[QUO_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg   <= dneg_reg[QUO_W] ? (~omag + IN_W'(1)) : omag;
            m_sat_reg <= dsat_reg[QUO_W];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;
    assign m_saturated  = m_sat_reg;

    // a saturated item carries full scale with its sign
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_sample_out == 32'sh7FFFFFFF || m_sample_out == 32'sh80000001))
        else $error("saturated item without full-scale value");

    // the most negative code never leaves the block
    a_no_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_out != 32'sh80000000)
        else $error("output hit the most negative code");

    // an output stall freezes the pipeline front and the last divider stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(v0_reg) && $stable(dv_reg[QUO_W]))
        else $error("pipeline moved during an output stall");

endmodule

>>> hdl/pts_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_mul
// Pipelined wide multiply-add p = a*b + c built from 32x32 partial products.
// ----------------------------------------------------------------------------
module pts_mul (
    input  logic           aclk,
    input  logic           en,
    input  pts_pkg::mula_t a,
    input  pts_pkg::mulb_t b,
    input  pts_pkg::prod_t c,
    output pts_pkg::prod_t p
);
    import pts_pkg::*;

    logic [2*DIG_W-1:0] pp_reg [MB_DIG][MA_DIG];
    prod_t              c1_reg, c2_reg;
    logic [ROW_W-1:0]   row_reg [MB_DIG];
    logic [ROW_W-1:0]   row_even [MB_DIG];
    logic [ROW_W-1:0]   row_odd  [MB_DIG];
    prod_t              p_reg;

    // stage 1: all digit products in parallel
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < MB_DIG; j++) begin
                for (int i = 0; i < MA_DIG; i++) begin
                    pp_reg[j][i] <= a[DIG_W*i +: DIG_W] * b[DIG_W*j +: DIG_W];
                end
            end
            c1_reg <= c;
        end
    end

    // even and odd digit products do not overlap within a row
    always_comb begin
        for (int j = 0; j < MB_DIG; j++) begin
            row_even[j] = '0;
            row_odd[j]  = '0;
            for (int i = 0; i < MA_DIG; i++) begin
                if (i % 2 == 0) row_even[j][DIG_W*i +: 2*DIG_W] = pp_reg[j][i];
                else            row_odd[j][DIG_W*i +: 2*DIG_W]  = pp_reg[j][i];
            end
        end
    end

    // stage 2: one add per row
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < MB_DIG; j++) begin
                row_reg[j] <= row_even[j] + row_odd[j];
            end
            c2_reg <= c1_reg;
        end
    end

    // stage 3: merge the rows and add the constant term
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= MP_W'(row_reg[0]) + (MP_W'(row_reg[1]) << DIG_W) + c2_reg;
        end
    end

    assign p = p_reg;

endmodule
